[hw/rtl/nmf_pkg.sv]
// shared types and constants for the navtex message framer
`default_nettype none

package nmf_pkg;

   localparam int OUT_POS_W = 48;

   localparam logic [1:0] MODE_HUNT     = 2'd0;
   localparam logic [1:0] MODE_PREAMBLE = 2'd1;
   localparam logic [1:0] MODE_BODY     = 2'd2;

   localparam logic [1:0] EMIT_HOLD     = 2'd0;
   localparam logic [1:0] EMIT_ROUTE    = 2'd1;
   localparam logic [1:0] EMIT_END_CUT  = 2'd2;
   localparam logic [1:0] EMIT_END_DONE = 2'd3;

   localparam logic       CSR_MAX_BODY  = 1'b0;

   localparam logic [6:0]  CH_Z      = 7'h5A;
   localparam logic [6:0]  CH_C      = 7'h43;
   localparam logic [6:0]  CH_N      = 7'h4E;
   localparam logic [6:0]  CH_QMARK  = 7'h3F;
   localparam logic [16:0] CH_SPACE  = 17'h00020;
   localparam logic [15:0] GL_CR     = 16'd13;
   localparam logic [15:0] GL_LF     = 16'd10;
   localparam logic [6:0]  LOST_KEY  = 7'h01;
   localparam logic [19:0] LOST_SAT  = 20'hFFFFF;
   localparam logic [20:0] LEN_SAT   = 21'h100000;
   localparam logic [19:0] MAX_BODY_RESET = 20'd16384;

   typedef struct packed {
      logic        kind;
      logic [15:0] text_glyph;
      logic        text_lost;
      logic        complete;
      logic [6:0]  area;
      logic [6:0]  subject;
      logic [6:0]  serial;
      logic        serial_ok;
      logic        header_clean;
      logic [19:0] lost_count;
      logic [47:0] start_pos;
   } nmf_res_type;

   typedef struct packed {
      logic       load_item;
      logic       set_epoch;
      logic       tail_upd;
      logic       clear_cut;
      logic       zczc_apply;
      logic       nnnn_apply;
      logic       pre_store;
      logic       parse_init;
      logic       parse_step;
      logic       parse_apply;
      logic       body_take;
      logic       pre_take;
      logic       set_begun;
      logic       pop_route;
      logic       dq_append;
      logic       drain_load_full;
      logic       drain_load_zczc;
      logic       drain_dec;
      logic       hold_append;
      logic       hold_pop;
      logic       dq_clear;
      logic       emit;
      logic [1:0] emit_sel;
      logic       flush;
   } nmf_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       ep_diff;
      logic       is_shift;
      logic       zczc;
      logic       nnnn;
      logic       item_le;
      logic       begun;
      logic       pre_last;
      logic       pidx_end;
      logic       dq_full;
      logic       drain_zero;
      logic       hold_empty;
      logic       hold_full;
      logic       route_le;
      logic       emit_ok;
      logic       pend_v;
      logic       out_free;
      logic       len_over;
   } nmf_sts_type;

endpackage

`default_nettype wire

[hw/rtl/nmf_ctrl.sv]
// sequencer for the framer: steps each word through tail, preamble and body work
`default_nettype none

module nmf_ctrl
   import nmf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire nmf_sts_type st,
   output nmf_cmd_type      cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EPOCH   = 4'd1;
   localparam logic [3:0] S_CHAR    = 4'd2;
   localparam logic [3:0] S_PARSE   = 4'd3;
   localparam logic [3:0] S_PUSHPRE = 4'd4;
   localparam logic [3:0] S_PUSH    = 4'd5;
   localparam logic [3:0] S_ROUTE   = 4'd6;
   localparam logic [3:0] S_DRAIN   = 4'd7;
   localparam logic [3:0] S_RELEASE = 4'd8;
   localparam logic [3:0] S_ENDREC  = 4'd9;
   localparam logic [3:0] S_BODYCHK = 4'd10;
   localparam logic [3:0] S_FINISH  = 4'd11;

   localparam logic [1:0] CONT_CHAR = 2'd0;
   localparam logic [1:0] CONT_ZCZC = 2'd1;
   localparam logic [1:0] CONT_LEN  = 2'd2;

   localparam logic RET_DRAIN = 1'b0;
   localparam logic RET_PUSH  = 1'b1;
   localparam logic PUSH_PRE  = 1'b0;
   localparam logic PUSH_BODY = 1'b1;

   logic [3:0] state_ff, state_in;
   logic [1:0] cont_ff, cont_in;
   logic       route_ret_ff, route_ret_in;
   logic       push_ret_ff, push_ret_in;
   logic       pre_push_ff, pre_push_in;
   logic [3:0] route_back;

   assign route_back = (route_ret_ff == RET_DRAIN) ? S_DRAIN : S_PUSH;

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      state_in     = state_ff;
      cont_in      = cont_ff;
      route_ret_in = route_ret_ff;
      push_ret_in  = push_ret_ff;
      pre_push_in  = pre_push_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_EPOCH;
            end
         end
         S_EPOCH: begin
            state_in = S_CHAR;
            if (st.ep_diff) begin
               cmd.set_epoch = 1'b1;
               if (st.mode != MODE_HUNT) begin
                  cmd.drain_load_full = 1'b1;
                  cont_in = CONT_CHAR;
                  state_in = S_DRAIN;
               end else begin
                  cmd.clear_cut = 1'b1;
               end
            end
         end
         S_CHAR: begin
            if (st.is_shift) begin
               state_in = S_FINISH;
            end else begin
               cmd.tail_upd = 1'b1;
               if (st.zczc) begin
                  if (st.mode != MODE_HUNT) begin
                     cmd.drain_load_zczc = 1'b1;
                     cont_in = CONT_ZCZC;
                     state_in = S_DRAIN;
                  end else begin
                     cmd.zczc_apply = 1'b1;
                     state_in = S_FINISH;
                  end
               end else if (st.mode == MODE_HUNT) begin
                  state_in = S_FINISH;
               end else if (st.mode == MODE_PREAMBLE) begin
                  if (st.item_le) begin
                     cmd.parse_init = 1'b1;
                     pre_push_in = 1'b0;
                     state_in = S_PARSE;
                  end else begin
                     cmd.pre_store = 1'b1;
                     if (st.pre_last) begin
                        cmd.parse_init = 1'b1;
                        pre_push_in = 1'b1;
                        state_in = S_PARSE;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
               end else if (!st.begun && st.item_le) begin
                  // leading line ends before the body are skipped
                  state_in = S_FINISH;
               end else begin
                  cmd.body_take = 1'b1;
                  push_ret_in = PUSH_BODY;
                  state_in = S_PUSH;
               end
            end
         end
         S_PARSE: begin
            if (st.pidx_end) begin
               cmd.parse_apply = 1'b1;
               state_in = pre_push_ff ? S_PUSHPRE : S_FINISH;
            end else begin
               cmd.parse_step = 1'b1;
            end
         end
         S_PUSHPRE: begin
            if (st.pidx_end) begin
               cmd.set_begun = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.pre_take = 1'b1;
               push_ret_in = PUSH_PRE;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (st.dq_full) begin
               cmd.pop_route = 1'b1;
               route_ret_in = RET_PUSH;
               state_in = S_ROUTE;
            end else begin
               cmd.dq_append = 1'b1;
               state_in = (push_ret_ff == PUSH_PRE) ? S_PUSHPRE : S_BODYCHK;
            end
         end
         S_ROUTE: begin
            if (st.route_le) begin
               if (st.hold_full) begin
                  // full hold lets the oldest line end go
                  if (st.emit_ok) begin
                     cmd.emit = 1'b1;
                     cmd.emit_sel = EMIT_HOLD;
                     cmd.hold_append = 1'b1;
                     state_in = route_back;
                  end
               end else begin
                  cmd.hold_append = 1'b1;
                  state_in = route_back;
               end
            end else if (!st.hold_empty) begin
               if (st.emit_ok) begin
                  cmd.emit = 1'b1;
                  cmd.emit_sel = EMIT_HOLD;
                  cmd.hold_pop = 1'b1;
               end
            end else if (st.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = EMIT_ROUTE;
               state_in = route_back;
            end
         end
         S_DRAIN: begin
            if (!st.drain_zero) begin
               cmd.pop_route = 1'b1;
               cmd.drain_dec = 1'b1;
               route_ret_in = RET_DRAIN;
               state_in = S_ROUTE;
            end else begin
               state_in = S_RELEASE;
            end
         end
         S_RELEASE: begin
            if (!st.hold_empty) begin
               if (st.emit_ok) begin
                  cmd.emit = 1'b1;
                  cmd.emit_sel = EMIT_HOLD;
                  cmd.hold_pop = 1'b1;
               end
            end else begin
               cmd.dq_clear = 1'b1;
               state_in = S_ENDREC;
            end
         end
         S_ENDREC: begin
            if (st.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = EMIT_END_CUT;
               unique case (cont_ff)
                  CONT_CHAR: begin
                     cmd.clear_cut = 1'b1;
                     state_in = S_CHAR;
                  end
                  CONT_ZCZC: begin
                     cmd.zczc_apply = 1'b1;
                     state_in = S_FINISH;
                  end
                  default: begin
                     cmd.clear_cut = 1'b1;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_BODYCHK: begin
            if (st.nnnn) begin
               if (st.emit_ok) begin
                  cmd.emit = 1'b1;
                  cmd.emit_sel = EMIT_END_DONE;
                  cmd.nnnn_apply = 1'b1;
                  state_in = S_FINISH;
               end
            end else if (st.len_over) begin
               cmd.drain_load_full = 1'b1;
               cont_in = CONT_LEN;
               state_in = S_DRAIN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!st.pend_v) begin
               state_in = S_IDLE;
            end else if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cont_ff      <= cont_in;
      route_ret_ff <= route_ret_in;
      push_ret_ff  <= push_ret_in;
      pre_push_ff  <= pre_push_in;
   end

endmodule

`default_nettype wire

[hw/rtl/nmf_datapath.sv]
// framer datapath: tail, preamble store, header, delay line, line end hold, result stage
`default_nettype none

module nmf_datapath
   import nmf_pkg::*;
#(
   parameter int PREAMBLE_MAX  = 8,
   parameter int LINE_END_HOLD = 8,
   parameter int POS_BITS      = 48
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire nmf_cmd_type cmd,
   output nmf_sts_type      st,
   input  wire logic [15:0] req_glyph,
   input  wire logic        req_lost,
   input  wire logic [47:0] req_sample_pos,
   input  wire logic [15:0] req_phase_epoch,
   input  wire logic [19:0] max_body,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output nmf_res_type      rsp_res,
   output logic             rsp_last
);

   localparam int PW = (POS_BITS < OUT_POS_W) ? POS_BITS : OUT_POS_W;
   localparam int PD = PREAMBLE_MAX + 1;
   localparam int IW = $clog2(PD);
   localparam int LW = $clog2(PD + 1);
   localparam int H  = LINE_END_HOLD;
   localparam int HW = $clog2(H + 1);

   function automatic logic is_letter(input logic [16:0] e);
      return (e >= 17'h41) && (e <= 17'h5A);
   endfunction

   function automatic logic is_digit(input logic [16:0] e);
      return (e >= 17'h30) && (e <= 17'h39);
   endfunction

   function automatic logic is_le(input logic [16:0] e);
      return !e[16] && ((e[15:0] == GL_CR) || (e[15:0] == GL_LF));
   endfunction

   // current item
   logic [15:0]   glyph_ff, glyph_in;
   logic          lost_ff, lost_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0]   ep_ff, ep_in;
   // framing state
   logic [1:0]    mode_ff, mode_in;
   logic [15:0]   epoch_ff, epoch_in;
   logic [6:0]    tk_ff [4];
   logic [6:0]    tk_in [4];
   logic [6:0]    tk_nx [4];
   logic [PW-1:0] tp_ff [4];
   logic [PW-1:0] tp_in [4];
   logic [PW-1:0] tp_nx [4];
   logic [2:0]    tn_ff, tn_in, tn_nx;
   logic [16:0]   pre_ff [PD];
   logic [16:0]   pre_in [PD];
   logic [LW-1:0] plen_ff, plen_in;
   logic [LW-1:0] pidx_ff, pidx_in;
   logic          sc_space_ff, sc_space_in;
   logic [2:0]    sc_nb_ff, sc_nb_in;
   logic [16:0]   sc_b_ff [4];
   logic [16:0]   sc_b_in [4];
   logic          begun_ff, begun_in;
   logic [20:0]   blen_ff, blen_in;
   logic [6:0]    area_ff, area_in;
   logic [6:0]    subj_ff, subj_in;
   logic [6:0]    serial_ff, serial_in;
   logic          ser_ok_ff, ser_ok_in;
   logic          clean_ff, clean_in;
   logic [PW-1:0] start_ff, start_in;
   logic [19:0]   lostt_ff, lostt_in;
   logic [16:0]   dq_ff [4];
   logic [16:0]   dq_in [4];
   logic [2:0]    dqn_ff, dqn_in;
   logic [H-1:0]  hold_ff, hold_in;
   logic [HW-1:0] holdn_ff, holdn_in;
   logic [16:0]   push_ff, push_in;
   logic [16:0]   route_ff, route_in;
   logic [2:0]    drain_ff, drain_in;
   // result stage
   nmf_res_type   pend_ff, pend_in;
   logic          pend_v_ff, pend_v_in;
   nmf_res_type   out_ff, out_in;
   logic          out_v_ff, out_v_in;
   logic          out_last_ff, out_last_in;

   logic [6:0]    key;
   logic [16:0]   item_e;
   logic [16:0]   pre_rd;
   logic [16:0]   take_e;
   logic          do_clear;
   logic          out_free;
   logic          emit_ok;
   logic          hb;
   logic [HW-1:0] hwr;
   logic [3:0]    d2, d3;
   logic          sok;
   nmf_res_type   res_new;

   assign item_e = {lost_ff, glyph_ff};
   assign key    = (lost_ff || (glyph_ff >= 16'h0080)) ? LOST_KEY : glyph_ff[6:0];
   assign pre_rd = pre_ff[pidx_ff[IW-1:0]];
   assign out_free = !out_v_ff || rsp_ready;
   assign emit_ok  = !pend_v_ff || out_free;

   // tail after taking this item's key
   always_comb begin
      tk_nx = tk_ff;
      tp_nx = tp_ff;
      if (tn_ff >= 3'd4) begin
         tk_nx[0] = tk_ff[1];
         tk_nx[1] = tk_ff[2];
         tk_nx[2] = tk_ff[3];
         tk_nx[3] = key;
         tp_nx[0] = tp_ff[1];
         tp_nx[1] = tp_ff[2];
         tp_nx[2] = tp_ff[3];
         tp_nx[3] = pos_ff;
         tn_nx = 3'd4;
      end else begin
         tk_nx[tn_ff[1:0]] = key;
         tp_nx[tn_ff[1:0]] = pos_ff;
         tn_nx = tn_ff + 3'd1;
      end
   end

   always_comb begin
      st.mode       = mode_ff;
      st.ep_diff    = ep_ff != epoch_ff;
      st.is_shift   = !lost_ff && (glyph_ff == 16'd0);
      st.zczc       = (tn_ff >= 3'd3) && (tk_nx[0] == CH_Z) && (tk_nx[1] == CH_C)
                      && (tk_nx[2] == CH_Z) && (tk_nx[3] == CH_C);
      st.nnnn       = (tn_ff == 3'd4) && (tk_ff[0] == CH_N) && (tk_ff[1] == CH_N)
                      && (tk_ff[2] == CH_N) && (tk_ff[3] == CH_N);
      st.item_le    = is_le(item_e);
      st.begun      = begun_ff;
      st.pre_last   = plen_ff == LW'(PREAMBLE_MAX);
      st.pidx_end   = pidx_ff == plen_ff;
      st.dq_full    = dqn_ff == 3'd4;
      st.drain_zero = drain_ff == 3'd0;
      st.hold_empty = holdn_ff == '0;
      st.hold_full  = holdn_ff == HW'(H);
      st.route_le   = is_le(route_ff);
      st.emit_ok    = emit_ok;
      st.pend_v     = pend_v_ff;
      st.out_free   = out_free;
      st.len_over   = blen_ff > {1'b0, max_body};
   end

   always_comb begin
      res_new = '0;
      unique case (cmd.emit_sel)
         EMIT_HOLD: begin
            res_new.text_glyph = hold_ff[0] ? GL_LF : GL_CR;
         end
         EMIT_ROUTE: begin
            res_new.text_glyph = route_ff[15:0];
            res_new.text_lost  = route_ff[16];
         end
         EMIT_END_CUT, EMIT_END_DONE: begin
            res_new.kind         = 1'b1;
            res_new.complete     = cmd.emit_sel == EMIT_END_DONE;
            res_new.area         = area_ff;
            res_new.subject      = subj_ff;
            res_new.serial       = serial_ff;
            res_new.serial_ok    = ser_ok_ff;
            res_new.header_clean = clean_ff;
            res_new.lost_count   = lostt_ff;
            res_new.start_pos    = OUT_POS_W'(start_ff);
         end
         default: begin
            res_new = '0;
         end
      endcase
   end

   assign d2  = sc_b_ff[2][3:0];
   assign d3  = sc_b_ff[3][3:0];
   assign sok = is_digit(sc_b_ff[2]) && is_digit(sc_b_ff[3]);
   assign hb  = route_ff[15:0] == GL_LF;
   assign take_e = cmd.body_take ? item_e : pre_rd;

   always_comb begin
      glyph_in = glyph_ff;
      lost_in  = lost_ff;
      pos_in   = pos_ff;
      ep_in    = ep_ff;
      mode_in  = mode_ff;
      epoch_in = epoch_ff;
      tk_in    = tk_ff;
      tp_in    = tp_ff;
      tn_in    = tn_ff;
      pre_in   = pre_ff;
      plen_in  = plen_ff;
      pidx_in  = pidx_ff;
      sc_space_in = sc_space_ff;
      sc_nb_in = sc_nb_ff;
      sc_b_in  = sc_b_ff;
      begun_in = begun_ff;
      blen_in  = blen_ff;
      area_in  = area_ff;
      subj_in  = subj_ff;
      serial_in = serial_ff;
      ser_ok_in = ser_ok_ff;
      clean_in = clean_ff;
      start_in = start_ff;
      lostt_in = lostt_ff;
      dq_in    = dq_ff;
      dqn_in   = dqn_ff;
      hold_in  = hold_ff;
      holdn_in = holdn_ff;
      push_in  = push_ff;
      route_in = route_ff;
      drain_in = drain_ff;
      pend_in  = pend_ff;
      pend_v_in = pend_v_ff;
      out_in   = out_ff;
      out_v_in = out_v_ff && !rsp_ready;
      out_last_in = out_last_ff;
      hwr      = holdn_ff;
      do_clear = cmd.clear_cut || cmd.zczc_apply || cmd.nnnn_apply;

      if (cmd.load_item) begin
         glyph_in = req_glyph;
         lost_in  = req_lost;
         pos_in   = req_sample_pos[PW-1:0];
         ep_in    = req_phase_epoch;
      end
      if (cmd.set_epoch) begin
         epoch_in = ep_ff;
      end
      if (cmd.tail_upd) begin
         tk_in = tk_nx;
         tp_in = tp_nx;
         tn_in = tn_nx;
      end

      // preamble store and its scan
      if (cmd.pre_store) begin
         pre_in[plen_ff[IW-1:0]] = item_e;
         plen_in = plen_ff + LW'(1);
      end
      if (cmd.parse_init) begin
         pidx_in = '0;
         sc_space_in = 1'b0;
         sc_nb_in = 3'd0;
      end
      if (cmd.parse_step) begin
         pidx_in = pidx_ff + LW'(1);
         if ((sc_nb_ff == 3'd0) && (pre_rd == CH_SPACE)) begin
            sc_space_in = 1'b1;
         end else begin
            if (sc_nb_ff < 3'd4) begin
               sc_b_in[sc_nb_ff[1:0]] = pre_rd;
            end
            if (sc_nb_ff < 3'd5) begin
               sc_nb_in = sc_nb_ff + 3'd1;
            end
         end
      end
      if (cmd.parse_apply) begin
         pidx_in = '0;
         mode_in = MODE_BODY;
         if (sc_nb_ff >= 3'd4) begin
            area_in   = is_letter(sc_b_ff[0]) ? sc_b_ff[0][6:0] : CH_QMARK;
            subj_in   = is_letter(sc_b_ff[1]) ? sc_b_ff[1][6:0] : CH_QMARK;
            ser_ok_in = sok;
            serial_in = sok ? (7'(d2) * 7'd10 + 7'(d3)) : 7'd0;
            clean_in  = sc_space_ff && (sc_nb_ff == 3'd4) && is_letter(sc_b_ff[0])
                        && is_letter(sc_b_ff[1]) && sok;
         end
      end

      // characters entering the delay line
      if (cmd.body_take || cmd.pre_take) begin
         push_in = take_e;
         if (take_e[16] && (lostt_ff < LOST_SAT)) begin
            lostt_in = lostt_ff + 20'd1;
         end
      end
      if (cmd.body_take) begin
         begun_in = 1'b1;
         if (blen_ff < LEN_SAT) begin
            blen_in = blen_ff + 21'd1;
         end
      end
      if (cmd.pre_take) begin
         pidx_in = pidx_ff + LW'(1);
      end
      if (cmd.set_begun) begin
         begun_in = 1'b1;
      end
      if (cmd.pop_route) begin
         route_in = dq_ff[0];
         dq_in[0] = dq_ff[1];
         dq_in[1] = dq_ff[2];
         dq_in[2] = dq_ff[3];
         dqn_in   = dqn_ff - 3'd1;
      end
      if (cmd.dq_append) begin
         dq_in[dqn_ff[1:0]] = push_ff;
         dqn_in = dqn_ff + 3'd1;
      end
      if (cmd.drain_load_full) begin
         drain_in = dqn_ff;
      end
      if (cmd.drain_load_zczc) begin
         // the ZCZ of the new opening stays behind
         drain_in = (dqn_ff == 3'd4) ? 3'd1 : 3'd0;
      end
      if (cmd.drain_dec) begin
         drain_in = drain_ff - 3'd1;
      end
      if (cmd.dq_clear) begin
         dqn_in = 3'd0;
      end

      // line end hold
      if (cmd.hold_pop || (cmd.hold_append && (holdn_ff == HW'(H)))) begin
         hold_in = hold_ff >> 1;
         hwr     = HW'(H - 1);
      end
      if (cmd.hold_pop) begin
         holdn_in = holdn_ff - HW'(1);
      end
      if (cmd.hold_append) begin
         for (int i = 0; i < H; i++) begin
            if (HW'(i) == hwr) begin
               hold_in[i] = hb;
            end
         end
         holdn_in = hwr + HW'(1);
      end

      // message clear, as on cut off, opening and closing
      if (do_clear) begin
         area_in   = CH_QMARK;
         subj_in   = CH_QMARK;
         serial_in = 7'd0;
         ser_ok_in = 1'b0;
         clean_in  = 1'b0;
         lostt_in  = 20'd0;
         start_in  = '0;
         plen_in   = '0;
         blen_in   = 21'd0;
         begun_in  = 1'b0;
         dqn_in    = 3'd0;
         holdn_in  = '0;
         mode_in   = MODE_HUNT;
      end
      if (cmd.clear_cut) begin
         tn_in = 3'd0;
      end
      if (cmd.zczc_apply) begin
         start_in = tp_in[0];
         mode_in  = MODE_PREAMBLE;
      end

      // two-deep result stage so the final word of an item can carry last
      if (cmd.emit) begin
         pend_in   = res_new;
         pend_v_in = 1'b1;
         if (pend_v_ff) begin
            out_in      = pend_ff;
            out_last_in = 1'b0;
            out_v_in    = 1'b1;
         end
      end
      if (cmd.flush) begin
         out_in      = pend_ff;
         out_last_in = 1'b1;
         out_v_in    = 1'b1;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HUNT;
         epoch_ff  <= 16'd0;
         tn_ff     <= 3'd0;
         plen_ff   <= '0;
         begun_ff  <= 1'b0;
         blen_ff   <= 21'd0;
         area_ff   <= CH_QMARK;
         subj_ff   <= CH_QMARK;
         serial_ff <= 7'd0;
         ser_ok_ff <= 1'b0;
         clean_ff  <= 1'b0;
         start_ff  <= '0;
         lostt_ff  <= 20'd0;
         dqn_ff    <= 3'd0;
         holdn_ff  <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         epoch_ff  <= epoch_in;
         tn_ff     <= tn_in;
         plen_ff   <= plen_in;
         begun_ff  <= begun_in;
         blen_ff   <= blen_in;
         area_ff   <= area_in;
         subj_ff   <= subj_in;
         serial_ff <= serial_in;
         ser_ok_ff <= ser_ok_in;
         clean_ff  <= clean_in;
         start_ff  <= start_in;
         lostt_ff  <= lostt_in;
         dqn_ff    <= dqn_in;
         holdn_ff  <= holdn_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      glyph_ff    <= glyph_in;
      lost_ff     <= lost_in;
      pos_ff      <= pos_in;
      ep_ff       <= ep_in;
      tk_ff       <= tk_in;
      tp_ff       <= tp_in;
      pre_ff      <= pre_in;
      pidx_ff     <= pidx_in;
      sc_space_ff <= sc_space_in;
      sc_nb_ff    <= sc_nb_in;
      sc_b_ff     <= sc_b_in;
      dq_ff       <= dq_in;
      hold_ff     <= hold_in;
      push_ff     <= push_in;
      route_ff    <= route_in;
      drain_ff    <= drain_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_res   = out_ff;
   assign rsp_last  = out_last_ff;

   a_dq_bound: assert property (@(posedge clock) disable iff (reset) dqn_ff <= 3'd4)
      else $error("delay line count beyond four");
   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      holdn_ff <= HW'(H))
      else $error("line end hold count beyond its depth");
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (rsp_valid && rsp_last))
      else $error("flushed word not shown as last");

endmodule

`default_nettype wire

[hw/rtl/navtex_message_framer.sv]
// navtex message framer top level: register port, sequencer and datapath
//
//  channel | ports  | handshake          | word
//  input   | req_*  | req_valid/ready    | one decoded character
//  result  | rsp_*  | rsp_valid/ready    | text character or message end record
//  config  | csr_*  | apb, pready tied 1 | max_body_chars at byte address 0
//
// one character at a time: a shift or hunt character passes the epoch check, character
// step and finish before the next req_ready; a body character adds a push and a body
// check, with further steps for overflows, held line ends and result words; ending an
// overlong preamble scans the stored entries and pushes each; a cut off drains each
// delay line entry, releases the held line ends and emits the end record.
// synchronous reset, no clearing pass; req_ready is low while a character is in work.
// a stalled rsp_ready holds the sequencer only when both result registers are full.
`default_nettype none

module navtex_message_framer
   import nmf_pkg::*;
#(
   parameter int PREAMBLE_MAX  = 8,
   parameter int LINE_END_HOLD = 8,
   parameter int POS_BITS      = 48
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_glyph,
   input  wire logic        req_lost,
   input  wire logic [47:0] req_sample_pos,
   input  wire logic [15:0] req_phase_epoch,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [15:0]      rsp_text_glyph,
   output logic             rsp_text_lost,
   output logic             rsp_complete,
   output logic [6:0]       rsp_area,
   output logic [6:0]       rsp_subject,
   output logic [6:0]       rsp_serial,
   output logic             rsp_serial_ok,
   output logic             rsp_header_clean,
   output logic [19:0]      rsp_lost_count,
   output logic [47:0]      rsp_start_pos,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [19:0] max_body_ff, max_body_in;
   logic        csr_hit;
   nmf_cmd_type cmd;
   nmf_sts_type st;
   nmf_res_type res;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == CSR_MAX_BODY;
   assign max_body_in = (csr_psel && csr_penable && csr_pwrite && csr_hit)
                        ? csr_pwdata[19:0] : max_body_ff;
   assign csr_prdata = csr_hit ? {12'd0, max_body_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= MAX_BODY_RESET;
      end else begin
         max_body_ff <= max_body_in;
      end
   end

   nmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   nmf_datapath #(
      .PREAMBLE_MAX  (PREAMBLE_MAX),
      .LINE_END_HOLD (LINE_END_HOLD),
      .POS_BITS      (POS_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_glyph       (req_glyph),
      .req_lost        (req_lost),
      .req_sample_pos  (req_sample_pos),
      .req_phase_epoch (req_phase_epoch),
      .max_body        (max_body_ff),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_res         (res),
      .rsp_last        (rsp_last)
   );

   assign rsp_kind         = res.kind;
   assign rsp_text_glyph   = res.text_glyph;
   assign rsp_text_lost    = res.text_lost;
   assign rsp_complete     = res.complete;
   assign rsp_area         = res.area;
   assign rsp_subject      = res.subject;
   assign rsp_serial       = res.serial;
   assign rsp_serial_ok    = res.serial_ok;
   assign rsp_header_clean = res.header_clean;
   assign rsp_lost_count   = res.lost_count;
   assign rsp_start_pos    = res.start_pos;

endmodule

`default_nettype wire
